[hw/rtl/exact_fit_free_list_allocator_core_defines.svh]
// Assertion macros, clocked on clk_i and disabled while rst_ni is low.
`ifndef EXACT_FIT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH
`define EXACT_FIT_FREE_LIST_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define EFFLA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define EFFLA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/effla_pkg.sv]
`default_nettype none

package effla_pkg;

  localparam int unsigned FREE_SLOTS = 16;
  localparam int unsigned IDX_W      = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(FREE_SLOTS + 1);

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned SIZE_W = 24;
  localparam int unsigned UNIT_W = 23;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;

  localparam logic CFG_HEAP_BASE = 1'b0;
  localparam logic CFG_HEAP_END  = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [UNIT_W-1:0] units;
  } entry_t;

endpackage

`default_nettype wire

[hw/rtl/exact_fit_free_list_allocator_core.sv]
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata {free_addr, req_size}, tuser kind
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata block_addr, tuser {from_table, status}
// cfg       in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One word at a time. A free goes straight to the done state. An allocate scans the
// table entries newest first (one per cycle through the registered table RAM read),
// then moves the entries above a hit down to close the gap (one per cycle), or bumps.
// Reset empties the free table and sets the bump pointer to zero; no clearing pass.
// A finished word waits in the output register; a new word is taken meanwhile.
// Config writes are taken only while idle with no input word offered.
`default_nettype none

module exact_fit_free_list_allocator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // req_size[23:0], free_addr[55:24]
  input  wire logic        s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // block_addr
  output logic [2:0]       m_axis_tuser,   // status[1:0], from_table[2]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  `include "exact_fit_free_list_allocator_core_defines.svh"

  localparam int unsigned IdxW = effla_pkg::IDX_W;
  localparam int unsigned CntW = effla_pkg::CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMPACT,
    ST_BUMP,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;
  logic [effla_pkg::UNIT_W-1:0] units_q;
  logic [31:0] bump_q;
  logic [31:0] heap_end_q;
  logic [31:0] res_addr_q;
  logic [1:0]  res_status_q;
  logic        res_reuse_q;
  logic        out_valid_q;
  logic [31:0] out_addr_q;
  logic [1:0]  out_status_q;
  logic        out_reuse_q;

  effla_pkg::entry_t mem_q [effla_pkg::FREE_SLOTS];
  effla_pkg::entry_t rd_data_q;

  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  effla_pkg::entry_t wr_data;

  logic in_acc;
  logic cfg_acc;
  logic out_load;
  logic [24:0] size_sum;
  logic [effla_pkg::UNIT_W-1:0] units_in;
  logic [31:0] in_addr;
  logic hit;
  logic srch_more;
  logic cmp_more;
  logic not_full;
  logic [32:0] bump_next;
  logic bump_fail;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = (state_q == ST_IDLE) && !s_axis_tvalid;
  assign cfg_acc       = cfg_valid_i && cfg_ready_o;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  assign size_sum  = {1'b0, s_axis_tdata[23:0]} + 25'd3;
  assign units_in  = size_sum[24:2];
  assign in_addr   = s_axis_tdata[55:24];
  assign not_full  = ({1'b0, count_q} < (CntW+1)'(effla_pkg::FREE_SLOTS));
  assign hit       = (rd_data_q.units == units_q);
  assign srch_more = ((CntW+1)'(idx_q) + (CntW+1)'(1)) < (CntW+1)'(count_q);
  assign cmp_more  = ((CntW+1)'(idx_q) + (CntW+1)'(2)) < (CntW+1)'(count_q);
  assign bump_next = {1'b0, bump_q} + {8'd0, units_q, 2'b00};
  assign bump_fail = (bump_next > {1'b0, heap_end_q});

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == effla_pkg::KIND_FREE) begin
            if (not_full) begin
              wr_en   = 1'b1;
              wr_addr = IdxW'(count_q);
              wr_data = '{addr: in_addr, units: units_in};
            end
          end else if (count_q != '0) begin
            rd_en   = 1'b1;
            rd_addr = IdxW'(count_q - CntW'(1));
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          if (srch_more) begin
            rd_en   = 1'b1;
            rd_addr = idx_q + IdxW'(1);
          end
        end else if (idx_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = idx_q - IdxW'(1);
        end
      end
      ST_COMPACT: begin
        wr_en   = 1'b1;
        wr_addr = idx_q;
        wr_data = rd_data_q;
        if (cmp_more) begin
          rd_en   = 1'b1;
          rd_addr = idx_q + IdxW'(2);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      units_q      <= '0;
      bump_q       <= '0;
      heap_end_q   <= '1;
      res_addr_q   <= '0;
      res_status_q <= effla_pkg::STATUS_OK;
      res_reuse_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      out_addr_q   <= '0;
      out_status_q <= effla_pkg::STATUS_OK;
      out_reuse_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            units_q     <= units_in;
            res_addr_q  <= '0;
            res_reuse_q <= 1'b0;
            if (s_axis_tuser == effla_pkg::KIND_FREE) begin
              if (not_full) begin
                count_q      <= count_q + CntW'(1);
                res_status_q <= effla_pkg::STATUS_OK;
              end else begin
                res_status_q <= effla_pkg::STATUS_FULL;
              end
              state_q <= ST_DONE;
            end else if (count_q != '0) begin
              idx_q   <= IdxW'(count_q - CntW'(1));
              state_q <= ST_SEARCH;
            end else begin
              state_q <= ST_BUMP;
            end
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            res_addr_q   <= rd_data_q.addr;
            res_reuse_q  <= 1'b1;
            res_status_q <= effla_pkg::STATUS_OK;
            if (srch_more) begin
              state_q <= ST_COMPACT;
            end else begin
              count_q <= count_q - CntW'(1);
              state_q <= ST_DONE;
            end
          end else if (idx_q == '0) begin
            state_q <= ST_BUMP;
          end else begin
            idx_q <= idx_q - IdxW'(1);
          end
        end
        ST_COMPACT: begin
          if (cmp_more) begin
            idx_q <= idx_q + IdxW'(1);
          end else begin
            count_q <= count_q - CntW'(1);
            state_q <= ST_DONE;
          end
        end
        ST_BUMP: begin
          res_reuse_q <= 1'b0;
          if (bump_fail) begin
            res_addr_q   <= '0;
            res_status_q <= effla_pkg::STATUS_EXHAUSTED;
          end else begin
            res_addr_q   <= bump_q;
            res_status_q <= effla_pkg::STATUS_OK;
            bump_q       <= bump_next[31:0];
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            out_addr_q   <= res_addr_q;
            out_status_q <= res_status_q;
            out_reuse_q  <= res_reuse_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cfg_acc) begin
        case (cfg_index_i)
          effla_pkg::CFG_HEAP_BASE: begin
            bump_q <= cfg_data_i;
          end
          effla_pkg::CFG_HEAP_END: begin
            heap_end_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = {out_reuse_q, out_status_q};

  `EFFLA_ASSERT_IMP(a_count_bound, 1'b1,
                    {1'b0, count_q} <= (CntW+1)'(effla_pkg::FREE_SLOTS),
                    "free count above table size")

  `EFFLA_ASSERT_IMP(a_idx_in_table, state_q == ST_SEARCH || state_q == ST_COMPACT,
                    (CntW+1)'(idx_q) < (CntW+1)'(count_q),
                    "table index outside live entries")

  `EFFLA_ASSERT_NXT(a_free_push, in_acc && s_axis_tuser == effla_pkg::KIND_FREE && not_full,
                    count_q == CntW'($past(count_q) + CntW'(1)),
                    "accepted free did not grow the table")

  `EFFLA_ASSERT_IMP(a_reuse_ok, m_axis_tvalid && m_axis_tuser[2],
                    m_axis_tuser[1:0] == effla_pkg::STATUS_OK,
                    "reused block reported with error status")

endmodule

`default_nettype wire
